[src/tkr_pkg.sv]
// Shared types, constants and register codes for the touch keypad serial reader.
package tkr_pkg;

   localparam int FRAME_BITS_DEFAULT = 16;
   localparam int TOUCH_W            = 16;
   localparam int TIMER_W            = 20;
   localparam int POLL_W             = 8;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 20;

   localparam logic [15:0]      START_LOW_RESET = 16'd1100;
   localparam logic [15:0]      HALF_BIT_RESET  = 16'd1000;
   localparam logic [TIMER_W-1:0] POLL_GAP_RESET = 20'd10000;
   localparam logic             INVERT_MASK_RESET = 1'b1;
   localparam logic [TOUCH_W-1:0] BUTTON_MASK_RESET = 16'h0000;
   localparam logic [POLL_W-1:0] PRESS_POLLS_RESET   = 8'd3;
   localparam logic [POLL_W-1:0] RELEASE_POLLS_RESET = 8'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_LOW     = 3'd0,
      CSR_HALF_BIT      = 3'd1,
      CSR_POLL_GAP      = 3'd2,
      CSR_INVERT_MASK   = 3'd3,
      CSR_BUTTON_MASK   = 3'd4,
      CSR_PRESS_POLLS   = 3'd5,
      CSR_RELEASE_POLLS = 3'd6
   } tkr_csr_index_type;

   typedef struct packed {
      logic [15:0]          start_low_ticks;
      logic [15:0]          half_bit_ticks;
      logic [TIMER_W-1:0]   poll_gap_ticks;
      logic                 invert_mask;
      logic [TOUCH_W-1:0]   button_mask;
      logic [POLL_W-1:0]    press_polls;
      logic [POLL_W-1:0]    release_polls;
   } tkr_cfg_type;

   typedef struct packed {
      logic                 scl_level;
      logic                 frame_done;
      logic [TOUCH_W-1:0]   word;
   } tkr_frame_type;

   typedef struct packed {
      logic                 scl_level;
      logic                 frame_done;
      logic [TOUCH_W-1:0]   touch_mask;
      logic                 button_down;
      logic                 just_pressed;
      logic                 just_released;
   } tkr_rsp_type;

endpackage

[src/tkr_req_if.sv]
// Input channel interface: one tick carrying the keypad data line level.
interface tkr_req_if;
   logic valid;
   logic ready;
   logic sdo_level;

   modport source (output valid, output sdo_level, input ready);
   modport sink (input valid, input sdo_level, output ready);
endinterface

[src/tkr_rsp_if.sv]
// Result channel interface: clock level, frame status and debounced button.
interface tkr_rsp_if
   import tkr_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic                 scl_level;
   logic                 frame_done;
   logic [TOUCH_W-1:0]   touch_mask;
   logic                 button_down;
   logic                 just_pressed;
   logic                 just_released;

   modport source (output valid, output scl_level, output frame_done, output touch_mask,
                   output button_down, output just_pressed, output just_released,
                   input ready);
   modport sink (input valid, input scl_level, input frame_done, input touch_mask,
                 input button_down, input just_pressed, input just_released,
                 output ready);
endinterface

[src/tkr_csr.sv]
// Configuration register bank with write-only access.
module tkr_csr
   import tkr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output tkr_cfg_type            cfg
);

   tkr_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low_ticks <= START_LOW_RESET;
         cfg_ff.half_bit_ticks  <= HALF_BIT_RESET;
         cfg_ff.poll_gap_ticks  <= POLL_GAP_RESET;
         cfg_ff.invert_mask     <= INVERT_MASK_RESET;
         cfg_ff.button_mask     <= BUTTON_MASK_RESET;
         cfg_ff.press_polls     <= PRESS_POLLS_RESET;
         cfg_ff.release_polls   <= RELEASE_POLLS_RESET;
      end else if (csr_we) begin
         case (tkr_csr_index_type'(csr_index))
            CSR_START_LOW:     cfg_ff.start_low_ticks <= csr_wdata[15:0];
            CSR_HALF_BIT:      cfg_ff.half_bit_ticks  <= csr_wdata[15:0];
            CSR_POLL_GAP:      cfg_ff.poll_gap_ticks  <= csr_wdata[TIMER_W-1:0];
            CSR_INVERT_MASK:   cfg_ff.invert_mask     <= csr_wdata[0];
            CSR_BUTTON_MASK:   cfg_ff.button_mask     <= csr_wdata[TOUCH_W-1:0];
            CSR_PRESS_POLLS:   cfg_ff.press_polls     <= csr_wdata[POLL_W-1:0];
            CSR_RELEASE_POLLS: cfg_ff.release_polls   <= csr_wdata[POLL_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/tkr_frame.sv]
// Clock line sequencer and serial shift register for one keypad frame.
module tkr_frame
   import tkr_pkg::*;
#(
   parameter int FRAME_BITS = FRAME_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic          sdo_level,
   input  tkr_cfg_type   cfg,
   output tkr_frame_type frame
);

   localparam int IDX_W = $clog2(FRAME_BITS + 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_START,
      PH_HIGH,
      PH_LOW
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [TIMER_W-1:0]     timer_ff, timer_in;
   logic [IDX_W-1:0]       bit_ff, bit_in;
   logic [FRAME_BITS-1:0]  shift_ff, shift_in;

   logic [TIMER_W-1:0]     len;
   logic [TIMER_W-1:0]     len_eff;
   logic [TIMER_W:0]       timer_inc;
   logic                   ends;
   logic [IDX_W-1:0]       bit_inc;
   logic [FRAME_BITS-1:0]  rev;
   logic [FRAME_BITS-1:0]  word;
   logic                   done;

   always_comb begin
      case (phase_ff)
         PH_IDLE:  len = cfg.poll_gap_ticks;
         PH_START: len = TIMER_W'(cfg.start_low_ticks);
         default:  len = TIMER_W'(cfg.half_bit_ticks);
      endcase
      len_eff   = (len == '0) ? TIMER_W'(1) : len;
      timer_inc = {1'b0, timer_ff} + (TIMER_W+1)'(1);
      ends      = timer_inc >= {1'b0, len_eff};
      bit_inc   = bit_ff + IDX_W'(1);

      phase_in = phase_ff;
      timer_in = timer_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      done     = 1'b0;
      if (step) begin
         if (!ends) begin
            timer_in = timer_inc[TIMER_W-1:0];
         end else begin
            timer_in = '0;
            case (phase_ff)
               PH_IDLE: begin
                  bit_in   = '0;
                  shift_in = '0;
                  phase_in = PH_START;
               end
               PH_START: phase_in = PH_HIGH;
               PH_HIGH: begin
                  shift_in = {shift_ff[FRAME_BITS-2:0], sdo_level};
                  phase_in = PH_LOW;
               end
               default: begin
                  if (bit_inc >= IDX_W'(FRAME_BITS)) begin
                     done     = 1'b1;
                     bit_in   = '0;
                     phase_in = PH_IDLE;
                  end else begin
                     bit_in   = bit_inc;
                     phase_in = PH_HIGH;
                  end
               end
            endcase
         end
      end
   end

   // chip sends the first pad first; reverse so bit n is pad n plus one
   always_comb begin
      for (int i = 0; i < FRAME_BITS; i++) begin
         rev[i] = shift_ff[FRAME_BITS-1-i];
      end
      word = cfg.invert_mask ? ~rev : rev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         timer_ff <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
      end
   end

   assign frame.scl_level  = (phase_ff == PH_IDLE) || (phase_ff == PH_HIGH);
   assign frame.frame_done = done;
   assign frame.word       = TOUCH_W'(word);

endmodule

[src/tkr_debounce.sv]
// Touch mask latch and button debounce with press and release edge flags.
module tkr_debounce
   import tkr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  tkr_cfg_type   cfg,
   input  tkr_frame_type frame,
   output tkr_rsp_type   result
);

   logic [TOUCH_W-1:0] touch_ff, touch_in;
   logic               stable_ff, stable_in;
   logic [POLL_W-1:0]  count_ff, count_in;
   logic               raw;
   logic [POLL_W-1:0]  need;
   logic [POLL_W-1:0]  count_inc;
   logic               update;

   always_comb begin
      update    = step && frame.frame_done;
      raw       = |(frame.word & cfg.button_mask);
      need      = raw ? cfg.press_polls : cfg.release_polls;
      count_inc = count_ff + POLL_W'(1);
      touch_in  = touch_ff;
      stable_in = stable_ff;
      count_in  = count_ff;
      if (update) begin
         touch_in = frame.word;
         if (raw == stable_ff) begin
            count_in = '0;
         end else if (count_inc >= need) begin
            stable_in = raw;
            count_in  = '0;
         end else begin
            count_in = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touch_ff  <= '0;
         stable_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         touch_ff  <= touch_in;
         stable_ff <= stable_in;
         count_ff  <= count_in;
      end
   end

   assign result.scl_level      = frame.scl_level;
   assign result.frame_done     = frame.frame_done;
   assign result.touch_mask     = touch_in;
   assign result.button_down    = stable_in;
   assign result.just_pressed   = update && !stable_ff && stable_in;
   assign result.just_released  = update && stable_ff && !stable_in;

endmodule

[src/tkr_out_buf.sv]
// Result register with a skid entry that absorbs one result under backpressure; the core stalls once it is full.
module tkr_out_buf
   import tkr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  tkr_rsp_type push_data,
   output logic        space,
   output logic        out_valid,
   input  logic        out_ready,
   output tkr_rsp_type out_data
);

   logic        main_valid_ff, skid_valid_ff;
   tkr_rsp_type main_ff, skid_ff;
   logic        pop;

   assign pop   = main_valid_ff && out_ready;
   assign space = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop && skid_valid_ff) begin
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         main_valid_ff <= push;
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_valid_ff) begin
         main_ff <= skid_ff;
      end else if (push && (pop || !main_valid_ff)) begin
         main_ff <= push_data;
      end
      if (push && main_valid_ff && !pop) begin
         skid_ff <= push_data;
      end
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

[src/touch_keypad_serial_reader.sv]
// Top level of the two-wire serial touch keypad reader.
// An accepted tick waits in the input register, then one pass of timer, shift and
// debounce logic puts its result into a result register with a skid entry. These
// set the throughput: one tick per cycle while the skid entry is free.
// Reset: synchronous, active high; clock line high in the idle gap, masks and button
// cleared, configuration registers back to their defaults.
module touch_keypad_serial_reader
   import tkr_pkg::*;
#(
   parameter int FRAME_BITS = FRAME_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   tkr_req_if.sink                req_ch,
   tkr_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic          in_valid_ff;
   logic          in_sdo_ff;
   logic          step;
   logic          space;
   tkr_cfg_type   cfg;
   tkr_frame_type frame;
   tkr_rsp_type   result;
   tkr_rsp_type   out_data;

   assign step         = in_valid_ff && space;
   assign req_ch.ready = !reset && (!in_valid_ff || step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_sdo_ff <= req_ch.sdo_level;
      end
   end

   tkr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tkr_frame #(
      .FRAME_BITS (FRAME_BITS)
   ) u_frame (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .sdo_level (in_sdo_ff),
      .cfg       (cfg),
      .frame     (frame)
   );

   tkr_debounce u_debounce (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .frame  (frame),
      .result (result)
   );

   tkr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (result),
      .space     (space),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_data)
   );

   assign rsp_ch.scl_level      = out_data.scl_level;
   assign rsp_ch.frame_done     = out_data.frame_done;
   assign rsp_ch.touch_mask     = out_data.touch_mask;
   assign rsp_ch.button_down    = out_data.button_down;
   assign rsp_ch.just_pressed   = out_data.just_pressed;
   assign rsp_ch.just_released  = out_data.just_released;

endmodule

[dv/touch_keypad_serial_reader_checker.sv]
// Checker: watches the keypad reader channels, predicts each result and compares it.
`timescale 1ns / 1ps

module touch_keypad_serial_reader_checker
   import tkr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   tkr_req_if                     req_mon,
   tkr_rsp_if                     rsp_mon,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   localparam int NBITS = FRAME_BITS_DEFAULT;

   typedef enum logic [1:0] {
      LINK_GAP   = 2'd0,
      LINK_START = 2'd1,
      LINK_HIGH  = 2'd2,
      LINK_LOW   = 2'd3
   } link_phase_type;

   tkr_cfg_type          regs;
   link_phase_type       phase;
   logic [TIMER_W-1:0]   timer;
   logic [4:0]           bit_count;
   logic [TOUCH_W-1:0]   shift;
   logic [TOUCH_W-1:0]   latched_mask;
   logic                 pressed;
   logic [POLL_W-1:0]    bounce_count;
   logic                 scl_now;
   tkr_rsp_type          expected_q[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report(input string what, input int got, input int exp);
      if (fail_count < 40)
         $display("ERROR %s: got %0h expected %0h", what, got, exp);
      fail_count++;
   endtask

   function automatic void goto_phase(input link_phase_type p);
      phase   = p;
      timer   = '0;
      scl_now = (p == LINK_GAP || p == LINK_HIGH);
   endfunction

   function automatic tkr_rsp_type predict_tick(input logic sdo);
      tkr_rsp_type        r;
      logic [TIMER_W-1:0] span;
      logic [TOUCH_W-1:0] word;
      logic               raw;
      logic               prev;
      logic [POLL_W-1:0]  need;
      r = '0;
      r.scl_level = scl_now;
      case (phase)
         LINK_GAP:   span = regs.poll_gap_ticks;
         LINK_START: span = TIMER_W'(regs.start_low_ticks);
         default:    span = TIMER_W'(regs.half_bit_ticks);
      endcase
      if (span == '0) span = TIMER_W'(1);
      if ({1'b0, timer} + 21'd1 < {1'b0, span}) begin
         timer = timer + 1'b1;
      end else begin
         case (phase)
            LINK_GAP: begin
               bit_count = '0;
               shift     = '0;
               goto_phase(LINK_START);
            end
            LINK_START: goto_phase(LINK_HIGH);
            LINK_HIGH: begin
               shift = {shift[TOUCH_W-2:0], sdo};
               goto_phase(LINK_LOW);
            end
            default: begin
               bit_count = bit_count + 1'b1;
               if (bit_count >= NBITS) begin
                  word = '0;
                  for (int i = 0; i < NBITS; i++) word[i] = shift[NBITS-1-i];
                  if (regs.invert_mask) word = ~word;
                  latched_mask = word;
                  prev = pressed;
                  raw  = (latched_mask & regs.button_mask) != '0;
                  if (raw == pressed) begin
                     bounce_count = '0;
                  end else begin
                     need = raw ? regs.press_polls : regs.release_polls;
                     bounce_count = bounce_count + 1'b1;
                     if (bounce_count >= need) begin
                        pressed      = raw;
                        bounce_count = '0;
                     end
                  end
                  r.frame_done    = 1'b1;
                  r.just_pressed  = !prev && pressed;
                  r.just_released = prev && !pressed;
                  bit_count = '0;
                  goto_phase(LINK_GAP);
               end else begin
                  goto_phase(LINK_HIGH);
               end
            end
         endcase
      end
      r.touch_mask     = latched_mask;
      r.button_down    = pressed;
      return r;
   endfunction

   always @(posedge clock) begin
      tkr_rsp_type exp_rsp;
      if (reset) begin
         regs.start_low_ticks = START_LOW_RESET;
         regs.half_bit_ticks  = HALF_BIT_RESET;
         regs.poll_gap_ticks  = POLL_GAP_RESET;
         regs.invert_mask     = INVERT_MASK_RESET;
         regs.button_mask     = BUTTON_MASK_RESET;
         regs.press_polls     = PRESS_POLLS_RESET;
         regs.release_polls   = RELEASE_POLLS_RESET;
         bit_count    = '0;
         shift        = '0;
         latched_mask = '0;
         pressed      = 1'b0;
         bounce_count = '0;
         goto_phase(LINK_GAP);
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_START_LOW:     regs.start_low_ticks = csr_wdata[15:0];
               CSR_HALF_BIT:      regs.half_bit_ticks  = csr_wdata[15:0];
               CSR_POLL_GAP:      regs.poll_gap_ticks  = csr_wdata[TIMER_W-1:0];
               CSR_INVERT_MASK:   regs.invert_mask     = csr_wdata[0];
               CSR_BUTTON_MASK:   regs.button_mask     = csr_wdata[TOUCH_W-1:0];
               CSR_PRESS_POLLS:   regs.press_polls     = csr_wdata[POLL_W-1:0];
               CSR_RELEASE_POLLS: regs.release_polls   = csr_wdata[POLL_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(predict_tick(req_mon.sdo_level));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               report("result transaction with none outstanding", 1, 0);
            end else begin
               exp_rsp = expected_q.pop_front();
               if (rsp_mon.scl_level !== exp_rsp.scl_level)
                  report("scl_level", rsp_mon.scl_level, exp_rsp.scl_level);
               if (rsp_mon.frame_done !== exp_rsp.frame_done)
                  report("frame_done", rsp_mon.frame_done, exp_rsp.frame_done);
               if (rsp_mon.touch_mask !== exp_rsp.touch_mask)
                  report("touch_mask", rsp_mon.touch_mask, exp_rsp.touch_mask);
               if (rsp_mon.button_down !== exp_rsp.button_down)
                  report("button_down", rsp_mon.button_down, exp_rsp.button_down);
               if (rsp_mon.just_pressed !== exp_rsp.just_pressed)
                  report("just_pressed", rsp_mon.just_pressed, exp_rsp.just_pressed);
               if (rsp_mon.just_released !== exp_rsp.just_released)
                  report("just_released", rsp_mon.just_released, exp_rsp.just_released);
            end
         end
      end
      pending <= expected_q.size();
   end

endmodule

[dv/touch_keypad_serial_reader_tb.sv]
// Testbench top: clock, reset, register writes, tick stimulus and the final verdict.
`timescale 1ns / 1ps

module touch_keypad_serial_reader_tb;
   import tkr_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int                     PHASES           = 10;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   no_idle = 1'b0;
   int                     stall_left = 0;
   int                     fail_count;
   int                     pending;

   tkr_req_if req_bus();
   tkr_rsp_if rsp_bus();

   touch_keypad_serial_reader i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   touch_keypad_serial_reader_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #1 clock = ~clock;

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_left > 0)
         stall_left--;
      else if (!no_idle && !reset && $urandom_range(0, 15) == 0)
         stall_left = $urandom_range(1, 19);
      rsp_bus.ready <= !reset && stall_left == 0;
   end

   task automatic send_tick(input logic sdo);
      int gap;
      if (!no_idle && $urandom_range(0, 15) == 0) begin
         gap = $urandom_range(1, 19);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.sdo_level <= sdo;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic apply_settings(input tkr_cfg_type c);
      write_reg(CSR_START_LOW, CSR_DATA_W'(c.start_low_ticks));
      write_reg(CSR_HALF_BIT, CSR_DATA_W'(c.half_bit_ticks));
      write_reg(CSR_POLL_GAP, CSR_DATA_W'(c.poll_gap_ticks));
      write_reg(CSR_INVERT_MASK, CSR_DATA_W'(c.invert_mask));
      write_reg(CSR_BUTTON_MASK, CSR_DATA_W'(c.button_mask));
      write_reg(CSR_PRESS_POLLS, CSR_DATA_W'(c.press_polls));
      write_reg(CSR_RELEASE_POLLS, CSR_DATA_W'(c.release_polls));
   endtask

   initial begin
      tkr_cfg_type cfg;
      int          ticks;
      int          hold_left;
      logic        hold_level;
      logic        noisy;
      logic        sdo;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.sdo_level <= 1'b0;
      hold_left  = 0;
      hold_level = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: a few ticks in the long idle gap
      for (int i = 0; i < 4; i++) send_tick(i[0]);
      drain();

      // zero durations and zero poll counts, then wide values and an unused index
      cfg = '{start_low_ticks: 16'd0, half_bit_ticks: 16'd0, poll_gap_ticks: 20'd0,
              invert_mask: 1'b0, button_mask: 16'hFFFF, press_polls: 8'd0,
              release_polls: 8'd0};
      apply_settings(cfg);
      write_reg(CSR_UNUSED_INDEX, 20'hFFFFF);
      write_reg(CSR_RELEASE_POLLS, 20'hFFF00);
      write_reg(CSR_START_LOW, 20'hF0000);
      csr_we <= 1'b0;
      for (int i = 0; i < 20; i++) send_tick((i % 3) == 0);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 3) begin
            cfg = '{start_low_ticks: 16'hFFFF, half_bit_ticks: 16'hFFFF,
                    poll_gap_ticks: 20'hFFFFF, invert_mask: 1'b1,
                    button_mask: 16'hFFFF, press_polls: 8'hFF, release_polls: 8'hFF};
            ticks = 40;
         end else if (ph == 6) begin
            cfg = '{start_low_ticks: 16'd1, half_bit_ticks: 16'd1, poll_gap_ticks: 20'd2000,
                    invert_mask: 1'b0, button_mask: 16'h0000, press_polls: 8'd1,
                    release_polls: 8'd1};
            ticks = 40;
         end else begin
            cfg.start_low_ticks = ($urandom_range(0, 3) == 0) ? 16'd0
                                                               : 16'($urandom_range(1, 6));
            cfg.half_bit_ticks  = 16'($urandom_range(0, 2));
            cfg.poll_gap_ticks  = ($urandom_range(0, 3) == 0) ? 20'd0
                                                               : 20'($urandom_range(1, 12));
            cfg.invert_mask     = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
               0:       cfg.button_mask = 16'h0000;
               1:       cfg.button_mask = 16'hFFFF;
               2:       cfg.button_mask = 16'h0001 << $urandom_range(0, 15);
               default: cfg.button_mask = 16'($urandom());
            endcase
            cfg.press_polls     = 8'($urandom_range(0, 4));
            cfg.release_polls   = 8'($urandom_range(0, 4));
            ticks = $urandom_range(190, 270);
         end
         apply_settings(cfg);
         csr_we <= 1'b0;
         if (ph == PHASES - 1) no_idle = 1'b1;
         noisy = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < ticks; k++) begin
            if (hold_left == 0) begin
               hold_level = 1'($urandom_range(0, 1));
               hold_left  = $urandom_range(20, 400);
            end
            hold_left--;
            if (noisy || $urandom_range(0, 31) == 0)
               sdo = 1'($urandom_range(0, 1));
            else
               sdo = hold_level;
            send_tick(sdo);
         end
         drain();
      end

      if (fail_count == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule
